>>> src/assert_macros.svh
// Assertion macros shared by the slot table modules.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/udpdm_pkg.sv
// Package for the UDP port demultiplexer slot table: sizes, codes, bus layouts.
// Used by the controller, the datapath and the top level; depends on nothing.
package udpdm_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int TRY_W = $clog2(NUM_SLOTS + 2);
	localparam int IN_DATA_W = 120;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_IDX_W = 2;

	localparam logic [16:0] RCVBUF_RESET = 17'd65536;
	localparam logic [15:0] EPH_FIRST_RESET = 16'd32768;
	localparam logic [15:0] EPH_LAST_RESET = 16'd60999;
	localparam logic [31:0] LOOPBACK_RESET = 32'h7F00_0001;

	typedef enum logic [2:0] {
		REQ_BIND    = 3'd0,
		REQ_CONNECT = 3'd1,
		REQ_CLOSE   = 3'd2,
		REQ_DELIVER = 3'd3,
		REQ_RELEASE = 3'd4,
		REQ_PREPARE = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_ALREADY  = 3'd1,
		STAT_INUSE    = 3'd2,
		STAT_NOTAVAIL = 3'd3,
		STAT_UNREACH  = 3'd4,
		STAT_NOLISTEN = 3'd5,
		STAT_FILTERED = 3'd6,
		STAT_FULL     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CFG_RCVBUF    = 2'd0,
		CFG_EPH_FIRST = 2'd1,
		CFG_EPH_LAST  = 2'd2,
		CFG_LOOPBACK  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SEARCH,
		S_COMMIT,
		S_DONE
	} fsm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic search_step;
		logic commit;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_search;
		logic search_done;
	} dp_sts_t;

endpackage

>>> src/udp_port_demux_table.sv
// Top level of the UDP port demultiplexer slot table.
// Joins udpdm_ctrl and udpdm_dp; uses udpdm_pkg.

// One request enters at a time. A request passes through accept, evaluate
// against all slots in parallel, commit, and load the result register.
// A bind with port zero, or a connect or prepare send on an unbound slot, adds
// an ephemeral search through the shared port conflict comparator. The search
// tests one candidate port per cycle, up to NUM_SLOTS + 1 candidates. When
// every candidate fails, a further search step notices that the tries are
// used up. The next request is taken while a finished result still waits on
// the output. Configuration writes are always taken.
module udp_port_demux_table (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// slot, addr, port, src_addr, src_port, length, addr_routable, zero fill
	input  logic [udpdm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// req_type
	input  logic [2:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// hit_slot, out_addr, out_port, drop_total, zero fill
	output logic [udpdm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status
	output logic [2:0]                            m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [udpdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                           cfg_data
);
	import udpdm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	udpdm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	udpdm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);
endmodule

>>> src/udpdm_ctrl.sv
// Controller state machine of the slot table: sequences accept, evaluate,
// ephemeral search, commit and result hand-off. Depends on udpdm_pkg.
`include "assert_macros.svh"

module udpdm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  udpdm_pkg::dp_sts_t sts,
	output udpdm_pkg::dp_cmd_t cmd
);
	import udpdm_pkg::*;

	fsm_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (s_axis_tvalid) state_d = S_EVAL;
			S_EVAL:   state_d = sts.need_search ? S_SEARCH : S_COMMIT;
			S_SEARCH: if (sts.search_done) state_d = S_COMMIT;
			S_COMMIT: state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		cmd = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load = s_axis_tvalid;
			end
			S_EVAL:   cmd.eval = 1'b1;
			S_SEARCH: cmd.search_step = 1'b1;
			S_COMMIT: cmd.commit = 1'b1;
			S_DONE:   cmd.emit = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new result never overwrites one that is still waiting.
	`ASSERT_CLK(a_no_overwrite, cmd.emit |-> out_free, "result overwritten")
	// A search is entered only when the evaluation asked for one.
	`ASSERT_NEXT(a_search_entry, state_q == S_EVAL && !sts.need_search,
		state_q == S_COMMIT, "unexpected search")
	// Input is taken only in the idle state.
	`ASSERT_CLK(a_load_idle, cmd.load |-> state_q == S_IDLE, "load outside idle")
endmodule

>>> src/udpdm_dp.sv
// Datapath of the slot table: slot registers, conflict compare, deliver match,
// ephemeral cursor, configuration registers and result register. Uses udpdm_pkg.
`include "assert_macros.svh"

module udpdm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  udpdm_pkg::dp_cmd_t                    cmd,
	output udpdm_pkg::dp_sts_t                    sts,
	input  logic [udpdm_pkg::IN_DATA_W-1:0]       in_data,
	input  logic [2:0]                            in_user,
	input  logic                                  cfg_we,
	input  logic [udpdm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [31:0]                           cfg_wdata,
	output logic [udpdm_pkg::OUT_DATA_W-1:0]      out_data,
	output logic [2:0]                            out_user
);
	import udpdm_pkg::*;

	// Configuration registers.
	logic [16:0] rcvbuf_q;
	logic [15:0] eph_first_q, eph_last_q;
	logic [31:0] loopback_q;

	// Slot table.
	logic        bound_q [NUM_SLOTS];
	logic [31:0] laddr_q [NUM_SLOTS];
	logic [15:0] lport_q [NUM_SLOTS];
	logic        conn_q  [NUM_SLOTS];
	logic [31:0] paddr_q [NUM_SLOTS];
	logic [15:0] pport_q [NUM_SLOTS];
	logic [16:0] fill_q  [NUM_SLOTS];
	logic [31:0] drops_q [NUM_SLOTS];
	logic [15:0] cursor_q;

	// Request registers.
	logic [2:0]  req_q;
	logic [3:0]  slot_q;
	logic [31:0] addr_q, saddr_q;
	logic [15:0] port_q, sport_q, len_q;
	logic        rout_q;

	// Evaluation results.
	logic [2:0]        status_q;
	logic [SLOT_W-1:0] sel_q;
	logic [3:0]        hit_q;
	logic              report_q;
	logic              need_q;
	logic [15:0]       alloc_q;
	logic [TRY_W-1:0]  try_q, tries_q;

	logic [31:0] out_addr_q, out_drop_q;
	logic [15:0] out_port_q;
	logic [3:0]  out_hit_q;
	logic [2:0]  out_status_q;

	// Shared port conflict compare.
	logic [31:0] tk_addr;
	logic [15:0] tk_port;
	logic        taken;
	logic [31:0] srch_addr;

	assign srch_addr = (req_q == REQ_BIND) ? addr_q : 32'd0;
	assign tk_addr = cmd.search_step ? srch_addr : addr_q;
	assign tk_port = cmd.search_step ? cursor_q : port_q;

	always_comb begin
		taken = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (bound_q[i] && lport_q[i] == tk_port &&
				(laddr_q[i] == tk_addr || laddr_q[i] == 32'd0 || tk_addr == 32'd0)) begin
				taken = 1'b1;
			end
		end
	end

	// Deliver match: lowest exact slot, else highest wildcard slot.
	logic              ex_hit, wd_hit;
	logic [SLOT_W-1:0] ex_idx, wd_idx;

	always_comb begin
		ex_hit = 1'b0;
		ex_idx = '0;
		wd_hit = 1'b0;
		wd_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (bound_q[i] && lport_q[i] == port_q && laddr_q[i] == addr_q) begin
				ex_hit = 1'b1;
				ex_idx = SLOT_W'(i);
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (bound_q[i] && lport_q[i] == port_q && laddr_q[i] != addr_q &&
				laddr_q[i] == 32'd0) begin
				wd_hit = 1'b1;
				wd_idx = SLOT_W'(i);
			end
		end
	end

	// Evaluation of the request against the table.
	logic [2:0]        ev_status;
	logic [SLOT_W-1:0] ev_sel;
	logic [3:0]        ev_hit;
	logic              ev_report;
	logic              ev_need;
	logic              slot_ok;
	logic [SLOT_W-1:0] m_idx;
	logic [17:0]       fill_sum;

	assign slot_ok = 32'(slot_q) < NUM_SLOTS;
	assign m_idx = ex_hit ? ex_idx : wd_idx;
	assign fill_sum = {1'b0, fill_q[m_idx]} + 18'(len_q);

	always_comb begin
		ev_status = STAT_OK;
		ev_sel = SLOT_W'(slot_q);
		ev_hit = slot_q;
		ev_report = 1'b0;
		ev_need = 1'b0;
		if (req_q == REQ_DELIVER) begin
			if (!ex_hit && !wd_hit) begin
				ev_status = STAT_NOLISTEN;
				ev_hit = 4'd0;
			end else begin
				ev_sel = m_idx;
				ev_hit = 4'(m_idx);
				ev_report = 1'b1;
				if (conn_q[m_idx] &&
					(paddr_q[m_idx] != saddr_q || pport_q[m_idx] != sport_q)) begin
					ev_status = STAT_FILTERED;
				end else if (fill_sum > {1'b0, rcvbuf_q}) begin
					ev_status = STAT_FULL;
				end
			end
		end else if (slot_ok) begin
			case (req_q)
				REQ_BIND: begin
					ev_report = 1'b1;
					if (addr_q != 32'd0 && !rout_q) begin
						ev_status = STAT_NOTAVAIL;
					end else if (bound_q[SLOT_W'(slot_q)]) begin
						ev_status = STAT_ALREADY;
					end else if (port_q == 16'd0) begin
						ev_need = 1'b1;
					end else if (taken) begin
						ev_status = STAT_INUSE;
					end
				end
				REQ_CONNECT: begin
					ev_report = 1'b1;
					if (!rout_q) begin
						ev_status = STAT_UNREACH;
					end else if (!bound_q[SLOT_W'(slot_q)]) begin
						ev_need = 1'b1;
					end
				end
				REQ_PREPARE: begin
					ev_report = 1'b1;
					ev_need = !bound_q[SLOT_W'(slot_q)];
				end
				REQ_CLOSE, REQ_RELEASE: ev_report = 1'b1;
				default: ev_report = 1'b0;
			endcase
		end
	end

	// Ephemeral range size, capped at one more than the slot count.
	logic [16:0]      range;
	logic [TRY_W-1:0] ev_tries;
	logic [16:0]      nx;
	logic             exhausted, found;

	assign range = {1'b0, eph_last_q} - {1'b0, eph_first_q} + 17'd1;
	always_comb begin
		if (eph_first_q > eph_last_q) begin
			ev_tries = '0;
		end else if (range < 17'(NUM_SLOTS + 1)) begin
			ev_tries = TRY_W'(range);
		end else begin
			ev_tries = TRY_W'(NUM_SLOTS + 1);
		end
	end

	assign nx = {1'b0, cursor_q} + 17'd1;
	assign exhausted = try_q >= tries_q;
	assign found = !exhausted && cursor_q != 16'd0 && !taken;
	assign sts.need_search = ev_need;
	assign sts.search_done = exhausted || found;

	// Request, evaluation and search registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_user;
			slot_q <= in_data[3:0];
			addr_q <= in_data[35:4];
			port_q <= in_data[51:36];
			saddr_q <= in_data[83:52];
			sport_q <= in_data[99:84];
			len_q <= in_data[115:100];
			rout_q <= in_data[116];
		end
		if (cmd.eval) begin
			status_q <= ev_status;
			sel_q <= ev_sel;
			hit_q <= ev_hit;
			report_q <= ev_report;
			need_q <= ev_need;
			try_q <= '0;
			tries_q <= ev_tries;
		end
		if (cmd.search_step) begin
			try_q <= try_q + TRY_W'(1);
			if (found) begin
				alloc_q <= cursor_q;
			end else if (exhausted) begin
				status_q <= STAT_INUSE;
			end
		end
	end

	// Configuration, cursor and slot table.
	logic        commit_ok;
	logic [15:0] new_port;

	assign commit_ok = cmd.commit && status_q == STAT_OK;
	assign new_port = need_q ? alloc_q : port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcvbuf_q <= RCVBUF_RESET;
			eph_first_q <= EPH_FIRST_RESET;
			eph_last_q <= EPH_LAST_RESET;
			loopback_q <= LOOPBACK_RESET;
			cursor_q <= EPH_FIRST_RESET;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				bound_q[i] <= 1'b0;
				laddr_q[i] <= '0;
				lport_q[i] <= '0;
				conn_q[i] <= 1'b0;
				paddr_q[i] <= '0;
				pport_q[i] <= '0;
				fill_q[i] <= '0;
				drops_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RCVBUF:    rcvbuf_q <= cfg_wdata[16:0];
					CFG_EPH_FIRST: eph_first_q <= cfg_wdata[15:0];
					CFG_EPH_LAST:  eph_last_q <= cfg_wdata[15:0];
					CFG_LOOPBACK:  loopback_q <= cfg_wdata;
					default:       loopback_q <= loopback_q;
				endcase
			end
			if (cmd.search_step && !exhausted) begin
				cursor_q <= (nx > {1'b0, eph_last_q}) ? eph_first_q : nx[15:0];
			end
			if (cmd.commit && report_q) begin
				case (req_q)
					REQ_BIND: if (commit_ok) begin
						bound_q[sel_q] <= 1'b1;
						laddr_q[sel_q] <= addr_q;
						lport_q[sel_q] <= new_port;
					end
					REQ_CONNECT: if (commit_ok) begin
						if (need_q) begin
							bound_q[sel_q] <= 1'b1;
							laddr_q[sel_q] <= 32'd0;
							lport_q[sel_q] <= alloc_q;
						end
						conn_q[sel_q] <= 1'b1;
						paddr_q[sel_q] <= addr_q;
						pport_q[sel_q] <= port_q;
					end
					REQ_PREPARE: if (commit_ok && need_q) begin
						bound_q[sel_q] <= 1'b1;
						laddr_q[sel_q] <= 32'd0;
						lport_q[sel_q] <= alloc_q;
					end
					REQ_CLOSE: begin
						bound_q[sel_q] <= 1'b0;
						laddr_q[sel_q] <= '0;
						lport_q[sel_q] <= '0;
						conn_q[sel_q] <= 1'b0;
						paddr_q[sel_q] <= '0;
						pport_q[sel_q] <= '0;
						fill_q[sel_q] <= '0;
						drops_q[sel_q] <= '0;
					end
					REQ_RELEASE: begin
						fill_q[sel_q] <= (fill_q[sel_q] > 17'(len_q)) ?
							fill_q[sel_q] - 17'(len_q) : 17'd0;
					end
					REQ_DELIVER: begin
						if (status_q == STAT_OK) begin
							fill_q[sel_q] <= fill_q[sel_q] + 17'(len_q);
						end else if (status_q == STAT_FULL && drops_q[sel_q] != '1) begin
							drops_q[sel_q] <= drops_q[sel_q] + 32'd1;
						end
					end
					default: fill_q[sel_q] <= fill_q[sel_q];
				endcase
			end
		end
	end

	// Result register, read from the slot after the commit.
	logic [31:0] rd_addr;

	always_comb begin
		rd_addr = laddr_q[sel_q];
		if (req_q == REQ_PREPARE && status_q == STAT_OK && rd_addr == 32'd0) begin
			rd_addr = loopback_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_hit_q <= hit_q;
			out_addr_q <= report_q ? rd_addr : 32'd0;
			out_port_q <= report_q ? lport_q[sel_q] : 16'd0;
			out_drop_q <= report_q ? drops_q[sel_q] : 32'd0;
		end
	end

	assign out_user = out_status_q;
	assign out_data = {4'd0, out_drop_q, out_port_q, out_addr_q, out_hit_q};

	// A successful bind leaves a nonzero local port in its slot.
	`ASSERT_NEXT(a_bind_port, commit_ok && req_q == REQ_BIND && report_q,
		lport_q[sel_q] != 16'd0, "bind left port zero")
	// An ephemeral hit never hands out port zero.
	`ASSERT_NEXT(a_alloc_nz, cmd.search_step && found, alloc_q != 16'd0,
		"port zero allocated")
	// The search never runs past its try budget.
	`ASSERT_CLK(a_try_bound, cmd.search_step |-> try_q <= tries_q, "search overran")
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the UDP port demultiplexer slot table.
// Depends on udpdm_pkg and udp_port_demux_table; a scoreboard class predicts every reply.
`timescale 1ns / 1ps

module tb_top;
	import udpdm_pkg::*;

	// Request codes the block treats as no-ops.
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [31:0] HOST_A = 32'h0A00_0001;
	localparam logic [31:0] HOST_B = 32'h0A00_0002;
	localparam logic [31:0] PEER_A = 32'h0B00_0001;

	typedef struct {
		logic [2:0]  status;
		logic [3:0]  hit;
		logic [31:0] laddr;
		logic [15:0] lport;
		logic [31:0] drops;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int cycle_count = 0;
	bit idle_enable = 1'b1;
	int sent_requests = 0;
	int config_writes = 0;

	// Slot table predictor with its own copy of state and registers.
	class slot_table_model;
		int unsigned rcv_limit, eph_first, eph_last, lo_addr, cursor;
		bit bound[NUM_SLOTS];
		bit connected[NUM_SLOTS];
		int unsigned laddr[NUM_SLOTS], lport[NUM_SLOTS], paddr[NUM_SLOTS];
		int unsigned pport[NUM_SLOTS], fill[NUM_SLOTS], drops[NUM_SLOTS];
		reply_t pending_replies[$];
		int mismatches, checked, refused;

		function new();
			rcv_limit = RCVBUF_RESET;
			eph_first = EPH_FIRST_RESET;
			eph_last = EPH_LAST_RESET;
			lo_addr = LOOPBACK_RESET;
			cursor = EPH_FIRST_RESET;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				clear_slot(i);
			end
		endfunction

		function void clear_slot(int i);
			bound[i] = 0; connected[i] = 0; laddr[i] = 0; lport[i] = 0;
			paddr[i] = 0; pport[i] = 0; fill[i] = 0; drops[i] = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] val);
			case (idx)
				CFG_RCVBUF: rcv_limit = val[16:0];
				CFG_EPH_FIRST: eph_first = val[15:0];
				CFG_EPH_LAST: eph_last = val[15:0];
				CFG_LOOPBACK: lo_addr = val;
				default: ;
			endcase
		endfunction

		// A wildcard on either side clashes with any address on the same port.
		function bit port_busy(int unsigned a, int unsigned p);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (bound[i] && lport[i] == p && (laddr[i] == a || laddr[i] == 0 || a == 0))
					return 1;
			end
			return 0;
		endfunction

		// Wrapping cursor search; zero means no port was found.
		function int unsigned next_ephemeral(int unsigned a);
			int unsigned span, tries, p;
			if (eph_first > eph_last) return 0;
			span = eph_last - eph_first + 1;
			tries = (span < NUM_SLOTS + 1) ? span : NUM_SLOTS + 1;
			for (int t = 0; t < tries; t++) begin
				p = cursor & 16'hFFFF;
				cursor = (p + 1 > eph_last) ? eph_first : p + 1;
				if (p != 0 && !port_busy(a, p)) return p;
			end
			return 0;
		endfunction

		function logic [2:0] implicit_bind(int s);
			int unsigned p;
			if (bound[s]) return STAT_OK;
			p = next_ephemeral(0);
			if (p == 0) return STAT_INUSE;
			laddr[s] = 0; lport[s] = p; bound[s] = 1;
			return STAT_OK;
		endfunction

		// Work out the reply of one accepted request and queue it.
		function void note_request(logic [2:0] rq, logic [3:0] slot, logic [31:0] addr,
				logic [15:0] port, logic [31:0] saddr, logic [15:0] sport,
				logic [15:0] len, logic routable);
			reply_t r;
			int s, exact, wild;
			int unsigned p;
			bit show;
			r = '{STAT_OK, slot, 0, 0, 0};
			show = 0;
			s = slot;
			if (rq == REQ_DELIVER) begin
				exact = -1; wild = -1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (bound[i] && lport[i] == port) begin
						if (laddr[i] == addr) begin
							if (exact < 0) exact = i;
						end else if (laddr[i] == 0) wild = i;
					end
				end
				if (exact < 0) exact = wild;
				if (exact < 0) begin
					r.status = STAT_NOLISTEN;
					r.hit = 0;
				end else begin
					s = exact;
					r.hit = 4'(s);
					show = 1;
					if (connected[s] && (paddr[s] != saddr || pport[s] != sport))
						r.status = STAT_FILTERED;
					else if (fill[s] + len > rcv_limit) begin
						if (drops[s] != 32'hFFFF_FFFF) drops[s]++;
						r.status = STAT_FULL;
						refused++;
					end else fill[s] += len;
				end
			end else if (rq <= REQ_PREPARE) begin
				show = 1;
				case (rq)
					REQ_BIND: begin
						if (addr != 0 && !routable) r.status = STAT_NOTAVAIL;
						else if (bound[s]) r.status = STAT_ALREADY;
						else begin
							p = port;
							if (p == 0) begin
								p = next_ephemeral(addr);
								if (p == 0) r.status = STAT_INUSE;
							end else if (port_busy(addr, p)) r.status = STAT_INUSE;
							if (r.status == STAT_OK) begin
								laddr[s] = addr; lport[s] = p; bound[s] = 1;
							end
						end
					end
					REQ_CONNECT: begin
						if (!routable) r.status = STAT_UNREACH;
						else begin
							r.status = implicit_bind(s);
							if (r.status == STAT_OK) begin
								paddr[s] = addr; pport[s] = port; connected[s] = 1;
							end
						end
					end
					REQ_CLOSE: clear_slot(s);
					REQ_RELEASE: fill[s] = (fill[s] > len) ? fill[s] - len : 0;
					default: r.status = implicit_bind(s);
				endcase
			end
			if (show) begin
				r.laddr = laddr[s];
				r.lport = 16'(lport[s]);
				r.drops = drops[s];
				if (rq == REQ_PREPARE && r.status == STAT_OK && r.laddr == 0)
					r.laddr = lo_addr;
			end
			pending_replies.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		endtask

		// Compare one reply with the oldest expectation, field by field.
		task check_response(logic [2:0] status, logic [OUT_DATA_W-1:0] d);
			reply_t e;
			if (pending_replies.size() == 0) begin
				report($sformatf("unexpected reply status %0d data %h", status, d));
				return;
			end
			e = pending_replies.pop_front();
			checked++;
			if (status !== e.status)
				report($sformatf("status %0d, expected %0d", status, e.status));
			if (d[3:0] !== e.hit)
				report($sformatf("hit_slot %0d, expected %0d", d[3:0], e.hit));
			if (d[35:4] !== e.laddr)
				report($sformatf("out_addr %h, expected %h", d[35:4], e.laddr));
			if (d[51:36] !== e.lport)
				report($sformatf("out_port %0d, expected %0d", d[51:36], e.lport));
			if (d[83:52] !== e.drops)
				report($sformatf("drop_total %0d, expected %0d", d[83:52], e.drops));
			if (d[87:84] !== 4'd0)
				report($sformatf("fill bits %h not zero", d[87:84]));
		endtask
	endclass

	slot_table_model table_model = new();

	udp_port_demux_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Reply side: random back-pressure, checked on every accepted transaction.
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= !idle_enable || ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			table_model.check_response(m_axis_tuser, m_axis_tdata);
	end

	// Drive one request; called and returning at a falling edge.
	task send_request(logic [2:0] rq, logic [3:0] slot, logic [31:0] addr,
			logic [15:0] port, logic [31:0] saddr, logic [15:0] sport,
			logic [15:0] len, logic routable);
		while (idle_enable && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= rq;
		s_axis_tdata <= {3'b0, routable, len, sport, saddr, port, addr, slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		table_model.note_request(rq, slot, addr, port, saddr, sport, len, routable);
		sent_requests++;
		@(negedge clk);
	endtask

	// Write one register once all replies are back and the block has settled.
	task write_register(cfg_idx_t idx, logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (table_model.pending_replies.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		table_model.write_reg(idx, val);
		config_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task set_registers(logic [16:0] rcv, logic [15:0] first, logic [15:0] last,
			logic [31:0] lo);
		write_register(CFG_RCVBUF, rcv);
		write_register(CFG_EPH_FIRST, first);
		write_register(CFG_EPH_LAST, last);
		write_register(CFG_LOOPBACK, lo);
	endtask

	// Random traffic: mostly well-formed binds, connects and deliveries on a small
	// set of ports and hosts, with some fully random requests mixed in.
	task random_traffic(int count);
		logic [2:0] rq;
		logic [3:0] slot, pick;
		logic [31:0] addr, saddr;
		logic [15:0] port, sport, len;
		logic routable;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			slot = 4'($urandom_range(15));
			pick = 4'($urandom_range(15));
			routable = ($urandom_range(9) != 0);
			case ($urandom_range(3))
				0: addr = 0;
				1: addr = HOST_A;
				2: addr = HOST_B;
				default: addr = $urandom;
			endcase
			case ($urandom_range(4))
				0, 1: port = 0;
				2: port = 53;
				3: port = 80;
				default: port = 16'($urandom);
			endcase
			saddr = ($urandom_range(2) != 0) ? PEER_A : $urandom;
			sport = ($urandom_range(2) != 0) ? 16'd1000 : 16'($urandom);
			len = ($urandom_range(4) != 0) ? 16'($urandom_range(4000)) : 16'($urandom);
			if (roll < 20) rq = REQ_BIND;
			else if (roll < 30) begin
				rq = REQ_CONNECT; addr = PEER_A; port = 1000;
				if ($urandom_range(3) == 0) begin
					addr = $urandom; port = 16'($urandom);
				end
			end else if (roll < 38) rq = REQ_CLOSE;
			else if (roll < 75) begin
				// Aim most deliveries at a port that some slot holds.
				rq = REQ_DELIVER;
				port = 16'(table_model.lport[pick]);
				if ($urandom_range(1)) addr = table_model.laddr[pick];
			end else if (roll < 85) rq = REQ_RELEASE;
			else if (roll < 95) rq = REQ_PREPARE;
			else if (roll < 97) rq = ($urandom_range(1)) ? REQ_SPARE_A : REQ_SPARE_B;
			else begin
				rq = 3'($urandom); addr = $urandom; port = 16'($urandom);
			end
			send_request(rq, slot, addr, port, saddr, sport, len, routable);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed checks under reset register values.
		send_request(REQ_BIND, 0, HOST_A, 80, 0, 0, 0, 1);
		send_request(REQ_BIND, 1, HOST_B, 80, 0, 0, 0, 1);
		send_request(REQ_BIND, 2, 0, 80, 0, 0, 0, 1);
		send_request(REQ_BIND, 0, HOST_B, 81, 0, 0, 0, 1);
		send_request(REQ_BIND, 3, 32'hFFFF_FFFF, 65535, 0, 0, 0, 0);
		send_request(REQ_BIND, 3, 0, 16'hFFFF, 0, 0, 0, 0);
		send_request(REQ_BIND, 4, HOST_A, 0, 0, 0, 0, 1);
		send_request(REQ_BIND, 5, 0, 53, 0, 0, 0, 1);
		send_request(REQ_DELIVER, 0, HOST_A, 80, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
		send_request(REQ_DELIVER, 0, HOST_B, 53, PEER_A, 1000, 16'hFFFF, 1);
		send_request(REQ_DELIVER, 0, HOST_B, 53, PEER_A, 1000, 2, 1);
		send_request(REQ_DELIVER, 0, HOST_B, 99, PEER_A, 1000, 1, 1);
		send_request(REQ_CONNECT, 6, PEER_A, 1000, 0, 0, 0, 0);
		send_request(REQ_CONNECT, 6, PEER_A, 1000, 0, 0, 0, 1);
		send_request(REQ_CONNECT, 5, PEER_A, 1000, 0, 0, 0, 1);
		send_request(REQ_DELIVER, 0, HOST_A, 53, PEER_A, 999, 5, 1);
		send_request(REQ_DELIVER, 0, HOST_A, 53, PEER_A, 1000, 5, 1);
		send_request(REQ_RELEASE, 5, 0, 0, 0, 0, 16'hFFFF, 0);
		send_request(REQ_PREPARE, 7, 0, 0, 0, 0, 0, 0);
		send_request(REQ_PREPARE, 0, 0, 0, 0, 0, 0, 0);
		send_request(REQ_CLOSE, 0, 0, 0, 0, 0, 0, 0);
		send_request(REQ_SPARE_A, 15, HOST_A, 80, 0, 0, 0, 1);
		send_request(REQ_SPARE_B, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 1);
		send_request(REQ_DELIVER, 0, 0, 0, 0, 0, 0, 1);
		random_traffic(150);

		// Register settings, extremes among them; one phase runs without idling.
		set_registers(17'd0, 16'd65534, 16'd65535, 32'h0);
		random_traffic(140);
		idle_enable = 1'b0;
		set_registers(17'd3000, 16'd1, 16'd1, 32'hFFFF_FFFF);
		random_traffic(140);
		idle_enable = 1'b1;
		set_registers(17'd65536, 16'd40000, 16'd39999, LOOPBACK_RESET);
		random_traffic(140);
		set_registers(17'd9000, 16'd100, 16'd105, $urandom);
		random_traffic(140);
		set_registers(17'd1, 16'd1, 16'd65535, $urandom);
		random_traffic(166);

		// Drain the reply queue, then let the block settle.
		s_axis_tvalid <= 1'b0;
		while (table_model.pending_replies.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests and %0d register writes; %0d replies checked.",
			sent_requests, config_writes, table_model.checked);
		$display("Predicted %0d datagrams refused for a full receive budget.",
			table_model.refused);
		if (table_model.mismatches == 0 && table_model.pending_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/udpdm_pkg.sv
src/udpdm_ctrl.sv
src/udpdm_dp.sv
src/udp_port_demux_table.sv
tb/tb_top.sv
